@@ rtl/tbds_pkg.sv @@
// Shared types and constants for the touch button debounce scanner.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package tbds_pkg;

  // Button count and the number of capacitive pads among them.
  localparam int unsigned NumButtons = 6;
  localparam int unsigned NumPads    = 5;

  // Default width of the stored time stamps.
  localparam int unsigned TimeWidthDefault = 32;

  // Field widths.
  localparam int unsigned NowWidth     = 32;
  localparam int unsigned ReadingWidth = 16;
  localparam int unsigned CfgWidth     = 16;
  localparam int unsigned ApbDataWidth = 32;
  localparam int unsigned ApbAddrWidth = 3;

  // Register indexes, taken from address bit 2.
  localparam logic RegTouchThreshold = 1'b0;
  localparam logic RegLockoutMs      = 1'b1;

  // Register reset values.
  localparam logic [CfgWidth-1:0] TouchThresholdReset = 16'd40;
  localparam logic [CfgWidth-1:0] LockoutMsReset      = 16'd50;

  // Bit position of the light button in the masks.
  localparam int unsigned LightBit = NumButtons - 1;

  // Configuration seen by the scan logic.
  typedef struct packed {
    logic [CfgWidth-1:0] pad_threshold;
    logic [CfgWidth-1:0] lockout_ms;
  } cfg_t;

endpackage

`default_nettype wire

@@ rtl/tbds_if.sv @@
// Valid/ready channel interfaces for scans coming in and results going out.
// Depends on tbds_pkg for the field widths.
`default_nettype none

interface tbds_scan_if;
  logic                                valid;
  logic                                ready;
  logic [tbds_pkg::NowWidth-1:0]       now_ms;
  logic [tbds_pkg::ReadingWidth-1:0]   pad_start;
  logic [tbds_pkg::ReadingWidth-1:0]   pad_stop;
  logic [tbds_pkg::ReadingWidth-1:0]   pad_select;
  logic [tbds_pkg::ReadingWidth-1:0]   pad_advance;
  logic [tbds_pkg::ReadingWidth-1:0]   pad_back;
  logic                                light_pin_level;

  modport source (
    output valid, now_ms, pad_start, pad_stop, pad_select,
           pad_advance, pad_back, light_pin_level,
    input  ready
  );
  modport sink (
    input  valid, now_ms, pad_start, pad_stop, pad_select,
           pad_advance, pad_back, light_pin_level,
    output ready
  );
endinterface

interface tbds_result_if;
  logic                                valid;
  logic                                ready;
  logic [tbds_pkg::NumButtons-1:0]     press_events;
  logic [tbds_pkg::NumButtons-1:0]     held_mask;
  logic                                light_on;

  modport source (
    output valid, press_events, held_mask, light_on,
    input  ready
  );
  modport sink (
    input  valid, press_events, held_mask, light_on,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/tbds_regs.sv @@
// APB configuration registers: touch threshold and lockout time.
// Depends on tbds_pkg for the register map, widths and reset values.
`default_nettype none

module tbds_regs (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [tbds_pkg::ApbAddrWidth-1:0] paddr,
  input  wire logic [tbds_pkg::ApbDataWidth-1:0] pwdata,
  output logic      [tbds_pkg::ApbDataWidth-1:0] prdata,
  output logic                                   pready,
  output tbds_pkg::cfg_t                         cfg_o
);

  logic [tbds_pkg::CfgWidth-1:0] threshold_q;
  logic [tbds_pkg::CfgWidth-1:0] lockout_q;
  logic                          wr_en;
  logic                          reg_sel;

  // The port never stalls.
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  // Register writes; only the low half of the data word is kept.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= tbds_pkg::TouchThresholdReset;
      lockout_q   <= tbds_pkg::LockoutMsReset;
    end else if (wr_en) begin
      unique case (reg_sel)
        tbds_pkg::RegTouchThreshold: threshold_q <= pwdata[tbds_pkg::CfgWidth-1:0];
        tbds_pkg::RegLockoutMs:      lockout_q   <= pwdata[tbds_pkg::CfgWidth-1:0];
        default:                     threshold_q <= threshold_q;
      endcase
    end
  end

  // Read back, zero-extended to the bus width.
  always_comb begin
    unique case (reg_sel)
      tbds_pkg::RegTouchThreshold: prdata = tbds_pkg::ApbDataWidth'(threshold_q);
      tbds_pkg::RegLockoutMs:      prdata = tbds_pkg::ApbDataWidth'(lockout_q);
      default:                     prdata = '0;
    endcase
  end

  assign cfg_o.pad_threshold = threshold_q;
  assign cfg_o.lockout_ms    = lockout_q;

endmodule

`default_nettype wire

@@ rtl/tbds_button.sv @@
// One button's lockout state: held flag and time of the last accepted press.
// Depends on tbds_pkg for the configuration width and default time width.
`default_nettype none

module tbds_button #(
  parameter int unsigned TimeWidth = tbds_pkg::TimeWidthDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_i,
  input  wire logic                          pressed_i,
  input  wire logic [TimeWidth-1:0]          now_i,
  input  wire logic [tbds_pkg::CfgWidth-1:0] lockout_i,
  output logic                               fire_o,
  output logic                               held_o
);

  logic [TimeWidth-1:0] last_q;
  logic [TimeWidth-1:0] last_d;
  logic                 held_q;
  logic                 held_d;
  logic [TimeWidth-1:0] gap;
  logic                 gap_open;

  // Wrapping time since the last accepted press, against the lockout.
  assign gap      = now_i - last_q;
  assign gap_open = gap > TimeWidth'(lockout_i);

  // A press fires only on a free button past the lockout. A press inside
  // the lockout leaves the flag clear so it may fire on a later scan.
  assign fire_o = pressed_i & ~held_q & gap_open;
  assign held_d = pressed_i & (held_q | fire_o);
  assign last_d = fire_o ? now_i : last_q;
  assign held_o = held_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
      last_q <= '0;
    end else if (step_i) begin
      held_q <= held_d;
      last_q <= last_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/touch_button_debounce_scanner_top.sv @@
// Top level of the touch button debounce scanner.
// Depends on tbds_pkg, tbds_if, tbds_regs and tbds_button.
`default_nettype none

// Takes one scan of five capacitive pads and a digital light pin with a
// millisecond time stamp, and returns one result per scan: the mask of
// presses accepted in that scan, the held mask and the light state. A new
// scan is accepted every clock cycle unless a full input register is stalled;
// each scan passes an input register, then the result register, and a scan
// can enter the input register while a result waits to be taken.
// A pad is pressed when its reading is below pad_threshold (byte address
// 0x0); the light pin is pressed when low. A press on a free button is
// accepted only when the wrapping time since its last accepted press exceeds
// lockout_ms (byte address 0x4). Write the registers only while idle.
module touch_button_debounce_scanner_top #(
  parameter int unsigned TimeWidth = tbds_pkg::TimeWidthDefault
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [tbds_pkg::ApbAddrWidth-1:0] paddr,
  input  wire logic [tbds_pkg::ApbDataWidth-1:0] pwdata,
  output logic      [tbds_pkg::ApbDataWidth-1:0] prdata,
  output logic                                   pready,
  tbds_scan_if.sink                              scan_i,
  tbds_result_if.source                          result_o
);

  localparam int unsigned NB = tbds_pkg::NumButtons;
  localparam int unsigned NP = tbds_pkg::NumPads;

  tbds_pkg::cfg_t cfg;

  logic                              in_valid_q;
  logic [tbds_pkg::NowWidth-1:0]     now_q;
  logic [tbds_pkg::ReadingWidth-1:0] pad_q [NP];
  logic                              light_level_q;

  logic                              out_valid_q;
  logic [NB-1:0]                     events_q;
  logic [NB-1:0]                     held_q;
  logic                              light_q;

  logic                              step;
  logic                              in_take;
  logic [TimeWidth-1:0]              now_t;
  logic [NB-1:0]                     pressed;
  logic [NB-1:0]                     fire;
  logic [NB-1:0]                     held_d;
  logic                              light_d;

  tbds_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake: the scan in the input register moves on when the result
  // register is empty or its result is transferred in this cycle.
  assign step         = in_valid_q & (~out_valid_q | result_o.ready);
  assign in_take      = scan_i.valid & scan_i.ready;
  assign scan_i.ready = ~in_valid_q | step;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (scan_i.ready) begin
      in_valid_q <= scan_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      now_q         <= scan_i.now_ms;
      pad_q[0]      <= scan_i.pad_start;
      pad_q[1]      <= scan_i.pad_stop;
      pad_q[2]      <= scan_i.pad_select;
      pad_q[3]      <= scan_i.pad_advance;
      pad_q[4]      <= scan_i.pad_back;
      light_level_q <= scan_i.light_pin_level;
    end
  end

  // Only the low TimeWidth bits of the stamp take part.
  assign now_t = TimeWidth'(now_q);

  // Press detection per button.
  always_comb begin
    for (int b = 0; b < NP; b++) begin
      pressed[b] = pad_q[b] < cfg.pad_threshold;
    end
    pressed[tbds_pkg::LightBit] = ~light_level_q;
  end

  // Per-button lockout state.
  for (genvar b = 0; b < NB; b++) begin : g_button
    tbds_button #(
      .TimeWidth (TimeWidth)
    ) u_button (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .step_i    (step),
      .pressed_i (pressed[b]),
      .now_i     (now_t),
      .lockout_i (cfg.lockout_ms),
      .fire_o    (fire[b]),
      .held_o    (held_d[b])
    );
  end

  // An accepted light press toggles the light.
  assign light_d = light_q ^ fire[tbds_pkg::LightBit];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_q <= 1'b0;
    end else if (step) begin
      light_q <= light_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      events_q <= fire;
      held_q   <= held_d;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.press_events = events_q;
  assign result_o.held_mask    = held_q;
  assign result_o.light_on     = light_q;

endmodule

`default_nettype wire
